// ===== hdl/bb3_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bb3_pkg;

  // Frame geometry and channel format.
  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 4096;
  localparam int CH_BITS     = 8;
  localparam int NUM_CH      = 3;
  localparam int PIX_BITS    = NUM_CH * CH_BITS;
  localparam int COL_BITS    = $clog2(MAX_WIDTH);
  localparam int WCNT_BITS   = COL_BITS + 1;
  localparam int ROW_BITS    = $clog2(MAX_HEIGHT);
  localparam int HCNT_BITS   = ROW_BITS + 1;

  // Configuration register fields.
  localparam int WIDTH_BITS  = 11;
  localparam int HEIGHT_BITS = 13;
  localparam int CFG_BITS    = HEIGHT_BITS;
  localparam int CFG_IDX_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT = 1'b1;

  // Input item kinds carried in tuser.
  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_DRAIN = 1'b1;

  // Mean arithmetic: a sum of at most nine channels, the rounding numerator
  // 2*sum+count, and a reciprocal of 2*count scaled by 2**RECIP_SHIFT.
  localparam int SUM_BITS    = $clog2(9 * (2**CH_BITS - 1) + 1);
  localparam int NUM_BITS    = SUM_BITS + 1;
  localparam int CNT_BITS    = 4;
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_BITS  = RECIP_SHIFT;
  localparam int PROD_BITS   = NUM_BITS + RECIP_BITS;

  localparam longint RECIP_2  = (2**RECIP_SHIFT + 1) / 2;
  localparam longint RECIP_4  = (2**RECIP_SHIFT + 3) / 4;
  localparam longint RECIP_6  = (2**RECIP_SHIFT + 5) / 6;
  localparam longint RECIP_8  = (2**RECIP_SHIFT + 7) / 8;
  localparam longint RECIP_12 = (2**RECIP_SHIFT + 11) / 12;
  localparam longint RECIP_18 = (2**RECIP_SHIFT + 17) / 18;

  typedef logic [PIX_BITS-1:0] pix_t;
  typedef logic [SUM_BITS-1:0] sum_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PIX,
    ST_SUM,
    ST_DRN,
    ST_MUL,
    ST_EMIT
  } bb3_state_t;

  // Rounded-up reciprocal of twice the pixel count. The error term stays far
  // below one for any numerator the window can produce, so the product
  // shifted down is the exact floor quotient.
  function automatic logic [RECIP_BITS-1:0] recip(input logic [CNT_BITS-1:0] n);
    logic [RECIP_BITS-1:0] r;
    case (n)
      4'd1:    r = RECIP_BITS'(RECIP_2);
      4'd2:    r = RECIP_BITS'(RECIP_4);
      4'd3:    r = RECIP_BITS'(RECIP_6);
      4'd4:    r = RECIP_BITS'(RECIP_8);
      4'd6:    r = RECIP_BITS'(RECIP_12);
      4'd9:    r = RECIP_BITS'(RECIP_18);
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [WCNT_BITS-1:0] clamp_width(input logic [WIDTH_BITS-1:0] d);
    int v;
    v = int'(d);
    if (v < 1) v = 1;
    if (v > MAX_WIDTH) v = MAX_WIDTH;
    return WCNT_BITS'(v);
  endfunction

  function automatic logic [HCNT_BITS-1:0] clamp_height(input logic [HEIGHT_BITS-1:0] d);
    int v;
    v = int'(d);
    if (v < 1) v = 1;
    if (v > MAX_HEIGHT) v = MAX_HEIGHT;
    return HCNT_BITS'(v);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/bb3_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM, one write and one registered read per cycle.
module bb3_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== hdl/box_blur_3x3_rgb.sv =====
`timescale 1ns / 1ps
`default_nettype none

// 3x3 box blur for RGB frames streamed in raster order. Each input word is
// either a pixel (tuser low) or a drain tick (tuser high). Every output
// channel is the mean of the in-frame pixels of the 3x3 neighborhood (four at
// corners, six on edges, nine inside), rounded half up with exact integer
// arithmetic. Results trail the input by one row and one pixel: a pixel at
// row r >= 1 and column c >= 1 yields the result for (r-1, c-1), and the last
// pixel of a row also yields the result for the row above's last column, so
// one pixel gives zero, one or two words; tlast marks the final word caused
// by an input word. After the frame's last pixel, pixels are dropped until
// one drain tick per column has flushed the bottom row; tuser on the output
// marks the frame's final pixel, after which the next pixel opens a new
// frame. Drain ticks with nothing pending are dropped. The user must write
// width and height through the cfg port only while the block is idle; the
// block itself does not enforce this. A write clamps the value to 1..1024
// columns or 1..4096 rows and restarts the frame. The two previous rows live
// in one 48-bit wide line RAM, addressed ahead of its data and written back
// in the cycle that data arrives. Input words are taken only in the idle
// state, so each is finished before the next is accepted, with the shared
// mean unit producing one word at a time; a drain tick reads its one to three
// columns from the RAM one per cycle. The output word sits in a register, so
// the next input word is taken while a finished word still waits for out_tready.
module box_blur_3x3_rgb (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // Input stream.
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [bb3_pkg::PIX_BITS-1:0]    in_tdata,  // in_red, in_green, in_blue
  input  wire logic                            in_tuser,  // func
  // Result stream.
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [bb3_pkg::PIX_BITS-1:0]         out_tdata, // out_red, out_green, out_blue
  output logic                                 out_tlast, // run_last
  output logic                                 out_tuser, // frame_end
  // Configuration writes.
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [bb3_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [bb3_pkg::CFG_BITS-1:0]    cfg_data
);

  import bb3_pkg::*;

  localparam int LINE_BITS = 2 * PIX_BITS;

  // Sequencer state and frame position.
  bb3_state_t             st_r, st_nxt;
  logic [WCNT_BITS-1:0]   w_eff_r;
  logic [HCNT_BITS-1:0]   h_eff_r;
  logic [COL_BITS-1:0]    col_cnt_r;
  logic [ROW_BITS-1:0]    row_cnt_r;
  logic [COL_BITS-1:0]    drn_cnt_r;
  logic                   drn_act_r;

  // Window and current result descriptor.
  pix_t                   win_r [3][3];   // [upper, middle, lower][oldest..newest]
  pix_t                   px_r;
  logic [1:0]             res_lo_r;
  logic [1:0]             b_lo_r;
  logic                   top_ok_r;
  logic                   pend_b_r;
  logic                   res_last_r;
  logic                   res_end_r;
  logic [COL_BITS-1:0]    dcol_r;
  logic [COL_BITS-1:0]    dhi_r;

  // Mean unit.
  sum_t                   sum_r [NUM_CH];
  logic [CNT_BITS-1:0]    cnt_r;
  logic [CH_BITS-1:0]     q_r [NUM_CH];
  sum_t                   win_sum [NUM_CH];
  logic [CNT_BITS-1:0]    win_cnt;
  logic [PROD_BITS-1:0]   prod [NUM_CH];

  // Output register.
  logic                   out_tvalid_r;
  pix_t                   out_data_r;
  logic                   out_last_r;
  logic                   out_end_r;

  // Line RAM: upper row in the high half, middle row in the low half.
  logic                   ram_we;
  logic [COL_BITS-1:0]    ram_rd_addr;
  logic [LINE_BITS-1:0]   ram_rd_data;
  pix_t                   line_up;
  pix_t                   line_mid;

  // Decodes.
  logic                   in_acc;
  logic                   cfg_wr;
  logic                   pix_go;
  logic                   drn_go;
  logic                   last_col;
  logic                   emit_any;
  logic                   out_free;
  logic                   out_load;
  logic                   drn_done;
  logic                   tall;
  logic [COL_BITS-1:0]    d_lo;
  logic [COL_BITS-1:0]    d_hi;
  logic                   d_final;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready;
  assign in_acc    = in_tvalid & in_tready;

  assign line_up  = ram_rd_data[PIX_BITS +: PIX_BITS];
  assign line_mid = ram_rd_data[0 +: PIX_BITS];

  assign tall     = h_eff_r >= HCNT_BITS'(2);
  assign last_col = (WCNT_BITS'(col_cnt_r) + WCNT_BITS'(1)) == w_eff_r;
  assign emit_any = (row_cnt_r != '0) && ((col_cnt_r != '0) || last_col);

  // A pixel while the bottom row is pending, or a drain tick with nothing
  // pending, is taken and dropped.
  assign pix_go = in_acc && (in_tuser == FUNC_PIXEL) && !drn_act_r &&
                  (WCNT_BITS'(col_cnt_r) < w_eff_r);
  assign drn_go = in_acc && (in_tuser == FUNC_DRAIN) && drn_act_r &&
                  (WCNT_BITS'(drn_cnt_r) < w_eff_r);

  // Columns that the drain result spans, clipped at the frame edges.
  assign d_lo    = (drn_cnt_r == '0) ? drn_cnt_r : drn_cnt_r - COL_BITS'(1);
  assign d_hi    = ((WCNT_BITS'(drn_cnt_r) + WCNT_BITS'(1)) < w_eff_r) ?
                   drn_cnt_r + COL_BITS'(1) : drn_cnt_r;
  assign d_final = (WCNT_BITS'(drn_cnt_r) + WCNT_BITS'(1)) == w_eff_r;
  assign drn_done = dcol_r == dhi_r;

  assign out_free = !out_tvalid_r || out_tready;

  bb3_ram #(
    .WIDTH (LINE_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (col_cnt_r),
    .wr_data ({line_mid, px_r}),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Next state.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: begin
        if (pix_go) begin
          st_nxt = ST_PIX;
        end else if (drn_go) begin
          st_nxt = ST_DRN;
        end
      end
      ST_PIX: begin
        st_nxt = emit_any ? ST_SUM : ST_IDLE;
      end
      ST_SUM: begin
        st_nxt = ST_MUL;
      end
      ST_DRN: begin
        if (drn_done) begin
          st_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        st_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          st_nxt = pend_b_r ? ST_SUM : ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs. The RAM is addressed in the cycle before its data is used.
  always_comb begin
    in_tready   = 1'b0;
    ram_we      = 1'b0;
    out_load    = 1'b0;
    ram_rd_addr = col_cnt_r;
    case (st_r)
      ST_IDLE: begin
        in_tready   = 1'b1;
        ram_rd_addr = (in_tuser == FUNC_DRAIN) ? d_lo : col_cnt_r;
      end
      ST_PIX: begin
        ram_we = 1'b1;
      end
      ST_DRN: begin
        ram_rd_addr = dcol_r + COL_BITS'(1);
      end
      ST_EMIT: begin
        out_load = out_free;
      end
      default: begin
        ram_rd_addr = col_cnt_r;
      end
    endcase
  end

  // Window sum for the current result: columns res_lo_r..2, with the upper
  // row only when it lies inside the frame.
  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      win_sum[ch] = '0;
    end
    win_cnt = '0;
    for (int row = 0; row < 3; row++) begin
      for (int col = 0; col < 3; col++) begin
        if (((row != 0) || top_ok_r) && (col >= int'(res_lo_r))) begin
          for (int ch = 0; ch < NUM_CH; ch++) begin
            win_sum[ch] = win_sum[ch] + SUM_BITS'(win_r[row][col][ch*CH_BITS +: CH_BITS]);
          end
          win_cnt = win_cnt + CNT_BITS'(1);
        end
      end
    end
  end

  // Rounded mean: (2*sum + count) / (2*count) by reciprocal multiplication.
  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      prod[ch] = PROD_BITS'({sum_r[ch], 1'b0} + NUM_BITS'(cnt_r)) *
                 PROD_BITS'(recip(cnt_r));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_IDLE;
      w_eff_r      <= WCNT_BITS'(1);
      h_eff_r      <= HCNT_BITS'(1);
      col_cnt_r    <= '0;
      row_cnt_r    <= '0;
      drn_cnt_r    <= '0;
      drn_act_r    <= 1'b0;
      pend_b_r     <= 1'b0;
      out_tvalid_r <= 1'b0;
      for (int row = 0; row < 3; row++) begin
        for (int col = 0; col < 3; col++) begin
          win_r[row][col] <= '0;
        end
      end
    end else begin
      st_r <= st_nxt;

      case (st_r)
        ST_IDLE: begin
          if (pix_go) begin
            px_r <= in_tdata;
          end
          if (drn_go) begin
            dcol_r     <= d_lo;
            dhi_r      <= d_hi;
            cnt_r      <= '0;
            res_last_r <= 1'b1;
            res_end_r  <= d_final;
            pend_b_r   <= 1'b0;
            for (int ch = 0; ch < NUM_CH; ch++) begin
              sum_r[ch] <= '0;
            end
            if (d_final) begin
              col_cnt_r <= '0;
              row_cnt_r <= '0;
              drn_cnt_r <= '0;
              drn_act_r <= 1'b0;
            end else begin
              drn_cnt_r <= drn_cnt_r + COL_BITS'(1);
            end
          end
        end

        ST_PIX: begin
          // Shift the window and bring in the new column; the line RAM
          // takes the write-back in this same cycle.
          for (int row = 0; row < 3; row++) begin
            win_r[row][0] <= win_r[row][1];
            win_r[row][1] <= win_r[row][2];
          end
          win_r[0][2] <= line_up;
          win_r[1][2] <= line_mid;
          win_r[2][2] <= px_r;

          top_ok_r  <= row_cnt_r >= ROW_BITS'(2);
          res_end_r <= 1'b0;
          b_lo_r    <= (col_cnt_r != '0) ? 2'd1 : 2'd2;
          if (col_cnt_r != '0) begin
            res_lo_r   <= (col_cnt_r >= COL_BITS'(2)) ? 2'd0 : 2'd1;
            res_last_r <= !last_col;
            pend_b_r   <= last_col;
          end else begin
            res_lo_r   <= 2'd2;
            res_last_r <= 1'b1;
            pend_b_r   <= 1'b0;
          end

          if (last_col) begin
            col_cnt_r <= '0;
            if ((HCNT_BITS'(row_cnt_r) + HCNT_BITS'(1)) >= h_eff_r) begin
              row_cnt_r <= '0;
              drn_cnt_r <= '0;
              drn_act_r <= 1'b1;
            end else begin
              row_cnt_r <= row_cnt_r + ROW_BITS'(1);
            end
          end else begin
            col_cnt_r <= col_cnt_r + COL_BITS'(1);
          end
        end

        ST_SUM: begin
          sum_r <= win_sum;
          cnt_r <= win_cnt;
        end

        ST_DRN: begin
          for (int ch = 0; ch < NUM_CH; ch++) begin
            sum_r[ch] <= sum_r[ch] + SUM_BITS'(line_mid[ch*CH_BITS +: CH_BITS]) +
                         (tall ? SUM_BITS'(line_up[ch*CH_BITS +: CH_BITS]) : SUM_BITS'(0));
          end
          cnt_r  <= cnt_r + (tall ? CNT_BITS'(2) : CNT_BITS'(1));
          dcol_r <= dcol_r + COL_BITS'(1);
        end

        ST_MUL: begin
          for (int ch = 0; ch < NUM_CH; ch++) begin
            q_r[ch] <= prod[ch][RECIP_SHIFT +: CH_BITS];
          end
        end

        ST_EMIT: begin
          if (out_free && pend_b_r) begin
            res_lo_r   <= b_lo_r;
            res_last_r <= 1'b1;
            pend_b_r   <= 1'b0;
          end
        end

        default: begin
          pend_b_r <= 1'b0;
        end
      endcase

      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end

      // Configuration takes effect at once and restarts the frame.
      if (cfg_wr) begin
        case (cfg_index)
          REG_WIDTH:  w_eff_r <= clamp_width(cfg_data[WIDTH_BITS-1:0]);
          REG_HEIGHT: h_eff_r <= clamp_height(cfg_data[HEIGHT_BITS-1:0]);
          default:    w_eff_r <= w_eff_r;
        endcase
        col_cnt_r <= '0;
        row_cnt_r <= '0;
        drn_cnt_r <= '0;
        drn_act_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        out_data_r[ch*CH_BITS +: CH_BITS] <= q_r[ch];
      end
      out_last_r <= res_last_r;
      out_end_r  <= res_end_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_end_r;

  // While the bottom row drains, the pixel counters sit at the frame start.
  a_drain_counters: assert property (@(posedge clk) disable iff (!rst_n)
    drn_act_r |-> (col_cnt_r == '0) && (row_cnt_r == '0))
    else $error("pixel counters moved while draining");

  // The mean unit only ever sees a pixel count of a real neighborhood.
  a_mean_count: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_MUL) |-> (cnt_r == 4'd1) || (cnt_r == 4'd2) || (cnt_r == 4'd3) ||
                         (cnt_r == 4'd4) || (cnt_r == 4'd6) || (cnt_r == 4'd9))
    else $error("mean unit started with an impossible pixel count");

  // A second result is pending only behind one that is not the last.
  a_pending_order: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_EMIT) && pend_b_r |-> !res_last_r)
    else $error("first of two results flagged as last");

  // The frame's final pixel always closes the words of its input item.
  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && out_end_r |-> out_last_r)
    else $error("frame end without last flag");

  // Line RAM write-back stays inside the configured row.
  a_wr_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (WCNT_BITS'(col_cnt_r) < w_eff_r))
    else $error("line write beyond the row width");

endmodule

`default_nettype wire
